@@ sv/fbpa_pkg.sv @@
package fbpa_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int SLOT_W     = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int ALIGN_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_STEPS  = ADDR_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int PROD_W     = SLOT_W + SIZE_W;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ALIGN  = 2'd3;

  localparam logic [SIZE_W-1:0]  BLOCK_BYTES_RST = 16'd16;
  localparam logic [ALIGN_W-1:0] BLOCK_ALIGN_RST = 13'd8;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_BAD       = 2'd2,
    STS_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INIT_DIV,
    S_FREE_DIV,
    S_LINK,
    S_MUL,
    S_ADD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    load;
    logic    init_start;
    logic    free_start;
    logic    init_commit;
    logic    free_commit;
    logic    alloc_head;
    logic    alloc_fresh;
    logic    alloc_link;
    logic    mul;
    logic    alloc_commit;
    logic    reject;
    status_t reject_code;
    logic    emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       alloc_bad;
    logic       head_valid;
    logic       fresh_avail;
    logic       free_zero;
    logic       free_outside;
    logic       div_done;
    logic       free_in_range;
  } dp_sts_t;

endpackage

@@ sv/fbpa_div.sv @@
module fbpa_div
  import fbpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [ADDR_W-1:0] quotient
);

  // Restoring radix-2 divider, one quotient bit per cycle. The dividend
  // register shifts out from the top while quotient bits enter at the bottom.
  logic [ADDR_W-1:0]    dvd_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [SIZE_W-1:0]    dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [SIZE_W:0] trial;
  logic [SIZE_W:0] diff;
  logic            ge;

  assign trial = {rem_r, dvd_r[ADDR_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ADDR_W-2:0], ge};
      rem_r <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (cnt_r == DIV_CNT_W'(DIV_STEPS - 1))) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ sv/fbpa_ctrl.sv @@
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.reject_code = STS_OK;
    in_ready        = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_t'(sts.op))
          OP_INIT: begin
            cmd.init_start = 1'b1;
            state_nxt      = S_INIT_DIV;
          end
          OP_ALLOC: begin
            if (sts.alloc_bad) begin
              cmd.reject      = 1'b1;
              cmd.reject_code = STS_BAD;
              state_nxt       = S_RESP;
            end else if (sts.head_valid) begin
              cmd.alloc_head = 1'b1;
              state_nxt      = S_LINK;
            end else if (sts.fresh_avail) begin
              cmd.alloc_fresh = 1'b1;
              state_nxt       = S_MUL;
            end else begin
              cmd.reject      = 1'b1;
              cmd.reject_code = STS_EMPTY;
              state_nxt       = S_RESP;
            end
          end
          OP_FREE: begin
            if (sts.free_zero) begin
              cmd.reject      = 1'b1;
              cmd.reject_code = STS_UNDERFLOW;
              state_nxt       = S_RESP;
            end else if (sts.free_outside) begin
              cmd.reject      = 1'b1;
              cmd.reject_code = STS_BAD;
              state_nxt       = S_RESP;
            end else begin
              cmd.free_start = 1'b1;
              state_nxt      = S_FREE_DIV;
            end
          end
          default: begin
            cmd.reject      = 1'b1;
            cmd.reject_code = STS_BAD;
            state_nxt       = S_RESP;
          end
        endcase
      end
      S_INIT_DIV: begin
        if (sts.div_done) begin
          cmd.init_commit = 1'b1;
          state_nxt       = S_RESP;
        end
      end
      S_FREE_DIV: begin
        if (sts.div_done) begin
          if (sts.free_in_range) begin
            cmd.free_commit = 1'b1;
          end else begin
            cmd.reject      = 1'b1;
            cmd.reject_code = STS_BAD;
          end
          state_nxt = S_RESP;
        end
      end
      S_LINK: begin
        cmd.alloc_link = 1'b1;
        cmd.mul        = 1'b1;
        state_nxt      = S_ADD;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.alloc_commit = 1'b1;
        state_nxt        = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/fbpa_dp.sv @@
module fbpa_dp
  import fbpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic [1:0]           in_op,
  input  logic [ADDR_W-1:0]    in_free_address,
  input  logic [SIZE_W-1:0]    in_request_size,
  input  logic [ALIGN_W-1:0]   in_request_align,
  input  ctl_cmd_t             cmd,
  output dp_sts_t              sts,
  output logic [ADDR_W-1:0]    out_block_address,
  output logic [1:0]           out_status,
  output logic [ADDR_W-1:0]    out_used_bytes,
  output logic [SLOT_W-1:0]    out_live_count
);

  // Configuration registers.
  logic [ADDR_W-1:0]  cfg_base_r;
  logic [ADDR_W-1:0]  cfg_bytes_r;
  logic [SIZE_W-1:0]  cfg_blk_r;
  logic [ALIGN_W-1:0] cfg_align_r;

  // Pool state.
  logic [SLOT_W-1:0]  head_r;
  logic [SLOT_W-1:0]  fresh_r;
  logic [SLOT_W-1:0]  total_r;
  logic [ADDR_W-1:0]  first_r;
  logic [SIZE_W-1:0]  eff_r;
  logic [ADDR_W-1:0]  used_r;
  logic [SLOT_W-1:0]  count_r;

  // Item registers.
  logic [1:0]         op_r;
  logic [ADDR_W-1:0]  faddr_r;
  logic [SIZE_W-1:0]  rsize_r;
  logic [ALIGN_W-1:0] ralign_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  link_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ADDR_W-1:0]  pend_first_r;
  logic [SIZE_W-1:0]  pend_eff_r;
  logic               pend_fits_r;

  // Staged result and output registers.
  logic [ADDR_W-1:0]  res_addr_r;
  logic [1:0]         res_status_r;
  logic [ADDR_W-1:0]  res_used_r;
  logic [SLOT_W-1:0]  res_count_r;
  logic [ADDR_W-1:0]  o_addr_r;
  logic [1:0]         o_status_r;
  logic [ADDR_W-1:0]  o_used_r;
  logic [SLOT_W-1:0]  o_count_r;

  // Free-list links; entries are only read after a free has written them.
  logic [SLOT_W-1:0]  link_mem [MAX_SLOTS];

  // Initialize arithmetic.
  logic [ALIGN_W-1:0] align_pow;
  logic [ADDR_W-1:0]  neg_base;
  logic [ALIGN_W-1:0] adj;
  logic [SIZE_W-1:0]  align_ext;
  logic [SIZE_W-1:0]  init_eff;
  logic [ADDR_W-1:0]  adj_ext;
  logic               init_fits;

  logic [ADDR_W-1:0]  div_dividend;
  logic [SIZE_W-1:0]  div_divisor;
  logic               div_start;
  logic               div_done;
  logic [ADDR_W-1:0]  quotient;
  logic [SLOT_W-1:0]  q_capped;

  always_comb begin
    align_pow = ALIGN_W'(1);
    for (int i = 0; i < ALIGN_W; i++) begin
      if (cfg_align_r[i]) begin
        align_pow = ALIGN_W'(1) << i;
      end
    end
  end

  assign neg_base  = ADDR_W'(0) - cfg_base_r;
  assign adj       = neg_base[ALIGN_W-1:0] & (align_pow - ALIGN_W'(1));
  assign adj_ext   = {{(ADDR_W-ALIGN_W){1'b0}}, adj};
  assign align_ext = {{(SIZE_W-ALIGN_W){1'b0}}, align_pow};
  assign init_eff  = (align_ext > cfg_blk_r) ? align_ext : cfg_blk_r;
  assign init_fits = (adj_ext <= cfg_bytes_r);

  assign div_start    = cmd.init_start | cmd.free_start;
  assign div_dividend = cmd.init_start ? (cfg_bytes_r - adj_ext) : (faddr_r - first_r);
  assign div_divisor  = cmd.init_start ? init_eff : eff_r;

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_capped = (quotient > ADDR_W'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS)
                                                    : quotient[SLOT_W-1:0];

  always_comb begin
    sts               = '0;
    sts.op            = op_r;
    sts.alloc_bad     = (rsize_r > eff_r) || (ralign_r > cfg_align_r);
    sts.head_valid    = (head_r < SLOT_W'(MAX_SLOTS));
    sts.fresh_avail   = (fresh_r < total_r);
    sts.free_zero     = (count_r == '0);
    sts.free_outside  = (faddr_r < first_r) || (eff_r == '0);
    sts.div_done      = div_done;
    sts.free_in_range = (quotient < {{(ADDR_W-SLOT_W){1'b0}}, total_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r  <= '0;
      cfg_bytes_r <= '0;
      cfg_blk_r   <= BLOCK_BYTES_RST;
      cfg_align_r <= BLOCK_ALIGN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_REGION_BASE:  cfg_base_r  <= cfg_wdata;
        REG_REGION_BYTES: cfg_bytes_r <= cfg_wdata;
        REG_BLOCK_BYTES:  cfg_blk_r   <= cfg_wdata[SIZE_W-1:0];
        REG_BLOCK_ALIGN:  cfg_align_r <= cfg_wdata[ALIGN_W-1:0];
        default:          cfg_base_r  <= cfg_base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= SLOT_W'(MAX_SLOTS);
      fresh_r <= '0;
      total_r <= '0;
      first_r <= '0;
      eff_r   <= '0;
      used_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.init_commit) begin
        head_r  <= SLOT_W'(MAX_SLOTS);
        fresh_r <= '0;
        total_r <= pend_fits_r ? q_capped : '0;
        first_r <= pend_first_r;
        eff_r   <= pend_eff_r;
        used_r  <= '0;
        count_r <= '0;
      end
      if (cmd.alloc_fresh) begin
        fresh_r <= fresh_r + SLOT_W'(1);
      end
      if (cmd.alloc_link) begin
        head_r <= link_r;
      end
      if (cmd.alloc_commit) begin
        used_r  <= used_r + {{(ADDR_W-SIZE_W){1'b0}}, eff_r};
        count_r <= count_r + SLOT_W'(1);
      end
      if (cmd.free_commit) begin
        head_r  <= quotient[SLOT_W-1:0];
        used_r  <= used_r - {{(ADDR_W-SIZE_W){1'b0}}, eff_r};
        count_r <= count_r - SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.free_commit) begin
      link_mem[quotient[IDX_W-1:0]] <= head_r;
    end
    if (cmd.alloc_head) begin
      link_r <= link_mem[head_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      faddr_r  <= in_free_address;
      rsize_r  <= in_request_size;
      ralign_r <= in_request_align;
    end
    if (cmd.init_start) begin
      pend_first_r <= cfg_base_r + adj_ext;
      pend_eff_r   <= init_eff;
      pend_fits_r  <= init_fits;
    end
    if (cmd.alloc_head) begin
      slot_r <= head_r;
    end
    if (cmd.alloc_fresh) begin
      slot_r <= fresh_r;
    end
    if (cmd.mul) begin
      prod_r <= slot_r * eff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      res_addr_r   <= '0;
      res_status_r <= cmd.reject_code;
      res_used_r   <= used_r;
      res_count_r  <= count_r;
    end
    if (cmd.init_commit) begin
      res_addr_r   <= '0;
      res_status_r <= STS_OK;
      res_used_r   <= '0;
      res_count_r  <= '0;
    end
    if (cmd.alloc_commit) begin
      res_addr_r   <= first_r + {{(ADDR_W-PROD_W){1'b0}}, prod_r};
      res_status_r <= STS_OK;
      res_used_r   <= used_r + {{(ADDR_W-SIZE_W){1'b0}}, eff_r};
      res_count_r  <= count_r + SLOT_W'(1);
    end
    if (cmd.free_commit) begin
      res_addr_r   <= '0;
      res_status_r <= STS_OK;
      res_used_r   <= used_r - {{(ADDR_W-SIZE_W){1'b0}}, eff_r};
      res_count_r  <= count_r - SLOT_W'(1);
    end
    if (cmd.emit) begin
      o_addr_r   <= res_addr_r;
      o_status_r <= res_status_r;
      o_used_r   <= res_used_r;
      o_count_r  <= res_count_r;
    end
  end

  assign out_block_address = o_addr_r;
  assign out_status        = o_status_r;
  assign out_used_bytes    = o_used_r;
  assign out_live_count    = o_count_r;

endmodule

@@ sv/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator. An initialize item aligns the region base
// up to the block alignment (rounded down to a power of two), raises the block
// size to that alignment when needed, and divides the region into at most
// 1024 slots; slots are then handed out from a LIFO free list backed by a
// watermark, so initialize needs no walk over the pool. Allocate returns the
// byte address of a block (0 with status empty or bad request), free turns an
// address back into a slot and pushes it. The block works on one item at a
// time: initialize and free run the 32-step radix-2 divider that maps a
// byte count to a slot; allocate takes the same steps on both the free-list
// and the watermark path (link memory read or watermark step, slot-times-size
// multiply, address add); items rejected at decode skip straight to the
// result transfer. The link memory has no reset and needs
// no clearing pass. A finished result waits in the output register while the
// next item is taken. Configuration may be written at any time the block is
// idle; the configuration channel is always ready.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data,
  // Request stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] free_address, [47:32] request_size, [60:48] request_align,
  // [63:61] zero.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation.
  input  logic [1:0]            in_tuser,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] block_address, [63:32] used_bytes, [74:64] live_count,
  // [79:75] zero.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status.
  output logic [1:0]            out_tuser
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  logic [ADDR_W-1:0] res_addr;
  logic [ADDR_W-1:0] res_used;
  logic [SLOT_W-1:0] res_count;

  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The request fields are captured by the datapath on the input transfer.
  fbpa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_idx           (cfg_index),
    .cfg_wdata         (cfg_data),
    .in_op             (in_tuser),
    .in_free_address   (in_tdata[ADDR_W-1:0]),
    .in_request_size   (in_tdata[ADDR_W+SIZE_W-1:ADDR_W]),
    .in_request_align  (in_tdata[ADDR_W+SIZE_W+ALIGN_W-1:ADDR_W+SIZE_W]),
    .cmd               (cmd),
    .sts               (sts),
    .out_block_address (res_addr),
    .out_status        (out_tuser),
    .out_used_bytes    (res_used),
    .out_live_count    (res_count)
  );

  assign out_tdata = {{(OUT_DATA_W-2*ADDR_W-SLOT_W){1'b0}}, res_count, res_used, res_addr};

endmodule

@@ sv/fbpa_chk.sv @@
module fbpa_chk
  import fbpa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // Any failed item reports address zero.
  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STS_OK) |-> out_tdata[ADDR_W-1:0] == '0)
    else $error("nonzero address with failing status");

  // Underflow is only reported with no live blocks.
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STS_UNDERFLOW) |->
      out_tdata[2*ADDR_W+SLOT_W-1:2*ADDR_W] == '0)
    else $error("underflow with live blocks");

endmodule

bind fixed_block_pool_allocator fbpa_chk u_fbpa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
